FILE: src/binary_cave_smoothing_stencil_core_defines.svh
// Assertion macros shared by the cave smoothing stencil RTL.
// Used by the top level; needs clk_i and rst_ni in the including scope.
`ifndef BINARY_CAVE_SMOOTHING_STENCIL_CORE_DEFINES_SVH
`define BINARY_CAVE_SMOOTHING_STENCIL_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BCSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BCSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BCSS_ASSERT(lbl, prop, msg)
`define BCSS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: src/bcss_pkg.sv
// Package of the cave smoothing stencil: beat types, register indexes and constants.
// No dependencies.
package bcss_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int SIZE_W     = 9;
  localparam int THR_W      = 4;
  localparam int CNT_W      = 4;
  localparam int WIN_ROWS   = 3;
  localparam int MIN_SIZE   = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIRTH_THR   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE_THR = 2'd3;

  localparam int RST_MAP_WIDTH  = 64;
  localparam int RST_MAP_HEIGHT = 64;
  localparam logic [THR_W-1:0] RST_BIRTH_THR   = 4'd5;
  localparam logic [THR_W-1:0] RST_SURVIVE_THR = 4'd4;

  typedef struct packed {
    logic cell_req;
    logic flush;
  } in_t;

  typedef struct packed {
    logic wall;
    logic last;
  } out_t;

endpackage

FILE: src/bcss_stream_if.sv
// Valid/ready stream interface carrying one beat of a given payload type.
// No dependencies; the payload type comes from bcss_pkg at instantiation.
interface bcss_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/bcss_win_cell.sv
// One column cell of the 3x3 window: holds three vertically stacked map cells.
// Depends on bcss_pkg.
module bcss_win_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          shift_i,
  input  logic [bcss_pkg::WIN_ROWS-1:0] col_i,
  output logic [bcss_pkg::WIN_ROWS-1:0] col_o
);

  logic [bcss_pkg::WIN_ROWS-1:0] col_q, col_d;

  assign col_d = shift_i ? col_i : col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  assign col_o = col_q;

endmodule

FILE: src/bcss_line_buf.sv
// Line store of the stencil: two previous rows per column, two bits per entry.
// Single write port and one registered read port; depends on nothing.
module bcss_line_buf #(
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [1:0]               wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [1:0]               rdata_o
);

  logic [1:0] mem [DEPTH];
  logic [1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/binary_cave_smoothing_stencil_core.sv
// Top level of the cave smoothing stencil: counters, window cells, rule and output queue.
// Depends on bcss_pkg, bcss_stream_if, bcss_win_cell, bcss_line_buf and the defines header.
//
// Channel   Direction  Beat fields
// in_i      sink       cell_req, flush
// out_o     source     wall, last
// cfg_*     write      cfg_we_i, cfg_idx_i, cfg_data_i
//
// One input beat is taken every cycle while the output queue has room; the line store read for
// the next column is issued ahead, so the store port sets this rate.
// A result enters the two-entry output queue in the cycle of the input beat that completes
// its window, map_width + 1 beats after its own cell, and can leave in the next cycle.
// Reset clears the counters, the window and the queue; the line store needs no clearing.
// The input stalls only while two results wait in the output queue.
module binary_cave_smoothing_stencil_core #(
  parameter int MAX_WIDTH  = bcss_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bcss_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  bcss_stream_if.sink                      in_i,
  bcss_stream_if.source                    out_o,
  input  logic                             cfg_we_i,
  input  logic [bcss_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bcss_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  `include "binary_cave_smoothing_stencil_core_defines.svh"

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int IRW  = $clog2(MAX_HEIGHT + 2);
  localparam int ORW  = $clog2(MAX_HEIGHT);
  localparam int SWW  = (WW > bcss_pkg::SIZE_W) ? WW : bcss_pkg::SIZE_W;
  localparam int SHW  = (HW > bcss_pkg::SIZE_W) ? HW : bcss_pkg::SIZE_W;
  localparam int ROWS = bcss_pkg::WIN_ROWS;
  localparam logic [WW-1:0] W_RST =
    WW'((MAX_WIDTH < bcss_pkg::RST_MAP_WIDTH) ? MAX_WIDTH : bcss_pkg::RST_MAP_WIDTH);
  localparam logic [HW-1:0] H_RST =
    HW'((MAX_HEIGHT < bcss_pkg::RST_MAP_HEIGHT) ? MAX_HEIGHT : bcss_pkg::RST_MAP_HEIGHT);

  // Configuration registers, sizes held already saturated.
  logic [WW-1:0]                  w_q;
  logic [HW-1:0]                  h_q;
  logic [bcss_pkg::THR_W-1:0]     birth_q, surv_q;
  logic [SWW-1:0]                 wr_w_ext;
  logic [SHW-1:0]                 wr_h_ext;
  logic [WW-1:0]                  w_clamp;
  logic [HW-1:0]                  h_clamp;

  assign wr_w_ext = SWW'(cfg_data_i);
  assign wr_h_ext = SHW'(cfg_data_i);
  assign w_clamp  = (wr_w_ext < SWW'(bcss_pkg::MIN_SIZE)) ? WW'(bcss_pkg::MIN_SIZE) :
                    (wr_w_ext > SWW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(wr_w_ext);
  assign h_clamp  = (wr_h_ext < SHW'(bcss_pkg::MIN_SIZE)) ? HW'(bcss_pkg::MIN_SIZE) :
                    (wr_h_ext > SHW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(wr_h_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q     <= W_RST;
      h_q     <= H_RST;
      birth_q <= bcss_pkg::RST_BIRTH_THR;
      surv_q  <= bcss_pkg::RST_SURVIVE_THR;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bcss_pkg::CFG_MAP_WIDTH:   w_q     <= w_clamp;
        bcss_pkg::CFG_MAP_HEIGHT:  h_q     <= h_clamp;
        bcss_pkg::CFG_BIRTH_THR:   birth_q <= cfg_data_i[bcss_pkg::THR_W-1:0];
        bcss_pkg::CFG_SURVIVE_THR: surv_q  <= cfg_data_i[bcss_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Position counters.
  logic [CW-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [IRW-1:0] in_row_q, in_row_d;
  logic [ORW-1:0] out_row_q, out_row_d;
  logic           in_acc, emit, col_wrap, ocol_end, orow_end, res_last, res_wall;
  logic           push, pop;
  logic [1:0]     lb_rdata;
  logic           v;
  logic [ROWS-1:0] new_col;

  assign in_acc   = in_i.valid && in_i.ready;
  assign v        = in_i.data.cell_req && !in_i.data.flush && (in_row_q < IRW'(h_q));
  assign new_col  = {v, lb_rdata[1], lb_rdata[0]};
  assign emit     = (in_row_q >= IRW'(2)) || ((in_row_q == IRW'(1)) && (in_col_q != '0));
  assign col_wrap = (WW'(in_col_q) + WW'(1)) >= w_q;
  assign ocol_end = (WW'(out_col_q) + WW'(1)) >= w_q;
  assign orow_end = (HW'(out_row_q) + HW'(1)) >= h_q;
  assign res_last = orow_end && ocol_end;

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (in_acc) begin
      if (col_wrap) begin
        in_col_d = '0;
        if (in_row_q != '1) begin
          in_row_d = in_row_q + IRW'(1);
        end
      end else begin
        in_col_d = in_col_q + CW'(1);
      end
      if (emit) begin
        if (res_last) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end else if (ocol_end) begin
          out_col_d = '0;
          out_row_d = out_row_q + ORW'(1);
        end else begin
          out_col_d = out_col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // Line store; the read address runs one column ahead of the write.
  bcss_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (in_col_q),
    .wdata_i ({v, lb_rdata[1]}),
    .raddr_i (in_col_d),
    .rdata_o (lb_rdata)
  );

  // Window cells: cell 1 holds the newest stored column, cell 0 the one before.
  logic [1:0][ROWS-1:0] win;
  logic [1:0][ROWS-1:0] chain_in;

  assign chain_in[1] = new_col;
  assign chain_in[0] = win[1];

  for (genvar g = 0; g < 2; g++) begin : g_cell
    bcss_win_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (in_acc),
      .col_i   (chain_in[g]),
      .col_o   (win[g])
    );
  end

  // Smoothing rule on the window as it stands after this beat.
  logic [ROWS-1:0]            row_mask, n0, n1, n2;
  logic [bcss_pkg::CNT_W-1:0] count;

  assign row_mask = {orow_end, 1'b0, out_row_q == '0};
  assign n0 = (out_col_q == '0) ? '1 : (win[0] | row_mask);
  assign n1 = win[1] | row_mask;
  assign n2 = ocol_end ? '1 : (new_col | row_mask);
  assign count = bcss_pkg::CNT_W'(n0[0]) + bcss_pkg::CNT_W'(n0[1]) +
                 bcss_pkg::CNT_W'(n0[2]) + bcss_pkg::CNT_W'(n1[0]) +
                 bcss_pkg::CNT_W'(n1[2]) + bcss_pkg::CNT_W'(n2[0]) +
                 bcss_pkg::CNT_W'(n2[1]) + bcss_pkg::CNT_W'(n2[2]);
  assign res_wall = win[1][1] ? (count >= surv_q) : (count >= birth_q);

  // Two-entry output queue.
  bcss_pkg::out_t fifo_q [2];
  bcss_pkg::out_t res;
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;

  assign res.wall = res_wall;
  assign res.last = res_last;
  assign push     = in_acc && emit;
  assign pop      = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  assign in_i.ready  = cnt_q != 2'd2;
  assign out_o.valid = cnt_q != '0;
  assign out_o.data  = fifo_q[rd_ptr_q];

  `BCSS_ASSERT(a_no_result_in_first_row, push |-> (in_row_q != '0), "result from first row")
  `BCSS_ASSERT_NEXT(a_frame_restart, push && res_last, (in_col_q == '0) && (in_row_q == '0) && (out_col_q == '0) && (out_row_q == '0), "counters not cleared after last")
  `BCSS_ASSERT_NEXT(a_queue_drain, pop && !push, cnt_q == ($past(cnt_q) - 2'd1), "queue count wrong")
  `BCSS_ASSERT_NEXT(a_window_hold, !in_acc, $stable(win), "window moved without a beat")

endmodule

FILE: tb/sv/bcss_smoothing_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the cave smoothing stencil: it mirrors the smoothing rule on every accepted
// input beat and checks each output beat against the oldest predicted cell.
// Depends on bcss_pkg for the beat types, register indexes and size limits.
module bcss_smoothing_checker
  import bcss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_t                   in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_t                  out_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    err_count_o,
  output int                    pending_o,
  output int                    results_o,
  output int                    frames_o
);

  logic [SIZE_W-1:0] width_q;
  logic [SIZE_W-1:0] height_q;
  logic [THR_W-1:0]  birth_q;
  logic [THR_W-1:0]  survive_q;
  logic [1:0]        row_pair [DEF_MAX_WIDTH];
  logic [8:0]        window_q;
  int                col_in;
  int                row_in;
  int                col_out;
  int                row_out;
  out_t              smoothed_q [$];
  out_t              due;
  int                errors;
  int                results;
  int                frames;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    errors++;
  endtask

  function automatic int fit_size(input logic [SIZE_W-1:0] v, input int hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  // Pushes the cell whose window this beat completes, if any.
  function automatic void advance_stencil(input logic cell_bit, input logic fl);
    int         w;
    int         h;
    int         col;
    int         count;
    int         rr;
    int         cc;
    logic       v;
    logic [1:0] pair;
    logic       emit;
    out_t       res;
    w = fit_size(width_q, DEF_MAX_WIDTH);
    h = fit_size(height_q, DEF_MAX_HEIGHT);
    v = fl ? 1'b0 : cell_bit;
    col = (col_in < DEF_MAX_WIDTH) ? col_in : DEF_MAX_WIDTH - 1;
    pair = row_pair[col];
    if (row_in >= h) v = 1'b0;
    row_pair[col] = {v, pair[1]};
    window_q = {v, pair, window_q[8:3]};
    emit = (row_in >= 2) || (row_in == 1 && col_in >= 1);
    if (col_in + 1 >= w) begin
      col_in = 0;
      if (row_in < 511) row_in++;
    end else begin
      col_in++;
    end
    if (emit) begin
      count = 0;
      for (int dc = 0; dc < 3; dc++) begin
        for (int dr = 0; dr < 3; dr++) begin
          rr = row_out - 1 + dr;
          cc = col_out - 1 + dc;
          if (!(dr == 1 && dc == 1)) begin
            if (rr < 0 || rr >= h || cc < 0 || cc >= w) count++;
            else count += window_q[dc * 3 + dr];
          end
        end
      end
      res.wall = window_q[4] ? (count >= survive_q) : (count >= birth_q);
      res.last = (row_out + 1 >= h) && (col_out + 1 >= w);
      smoothed_q.push_back(res);
      if (res.last) begin
        col_in = 0;
        row_in = 0;
        col_out = 0;
        row_out = 0;
      end else if (col_out + 1 >= w) begin
        col_out = 0;
        row_out++;
      end else begin
        col_out++;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q = SIZE_W'(RST_MAP_WIDTH);
      height_q = SIZE_W'(RST_MAP_HEIGHT);
      birth_q = RST_BIRTH_THR;
      survive_q = RST_SURVIVE_THR;
      foreach (row_pair[k]) row_pair[k] = '0;
      window_q = '0;
      col_in = 0;
      row_in = 0;
      col_out = 0;
      row_out = 0;
      smoothed_q.delete();
      errors = 0;
      results = 0;
      frames = 0;
      err_count_o <= 0;
      pending_o <= 0;
      results_o <= 0;
      frames_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAP_WIDTH: width_q = cfg_data_i;
          CFG_MAP_HEIGHT: height_q = cfg_data_i;
          CFG_BIRTH_THR: birth_q = cfg_data_i[THR_W-1:0];
          CFG_SURVIVE_THR: survive_q = cfg_data_i[THR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) advance_stencil(in_data_i.cell_req, in_data_i.flush);
      if (out_valid_i && out_ready_i) begin
        if (smoothed_q.size() == 0) begin
          report_mismatch($sformatf("beat wall=%0b last=%0b arrived with no cell due",
                                    out_data_i.wall, out_data_i.last));
        end else begin
          due = smoothed_q.pop_front();
          if (out_data_i.wall !== due.wall)
            report_mismatch($sformatf("cell %0d wall=%0b, predicted %0b",
                                      results, out_data_i.wall, due.wall));
          if (out_data_i.last !== due.last)
            report_mismatch($sformatf("cell %0d last=%0b, predicted %0b",
                                      results, out_data_i.last, due.last));
          results++;
          if (due.last) frames++;
        end
      end
      err_count_o <= errors;
      pending_o <= smoothed_q.size();
      results_o <= results;
      frames_o <= frames;
    end
  end

endmodule

FILE: tb/sv/tb_binary_cave_smoothing_stencil_core.sv
`timescale 1ns / 100ps
// Top of the cave smoothing stencil testbench: clock, reset, map streams, register writes and
// the verdict. Depends on bcss_pkg, bcss_stream_if, the core and bcss_smoothing_checker.
module tb_binary_cave_smoothing_stencil_core;
  import bcss_pkg::*;

  localparam int RESET_CYCLES  = 12;
  localparam int QUIET_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 20;
  localparam int HOLD_CYCLES   = 120;
  localparam int SMALL_ITEMS   = 300;
  localparam int IDLE_PCT      = 20;
  localparam logic [8:0] CHEQUER = 9'b1_0101_0101;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  bit                    sink_gaps = 1'b1;
  int                    hold_seq = 0;
  bit                    src_gaps = 1'b1;
  int                    map_w = RST_MAP_WIDTH;
  int                    map_h = RST_MAP_HEIGHT;
  int                    beats_sent = 0;
  int                    settings = 0;
  int                    err_count;
  int                    pending;
  int                    results;
  int                    frames;

  bcss_stream_if #(.payload_t(in_t))  in_if ();
  bcss_stream_if #(.payload_t(out_t)) out_if ();

  binary_cave_smoothing_stencil_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  bcss_smoothing_checker u_scoreboard (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_i  (in_if.ready),
    .in_data_i   (in_if.data),
    .out_valid_i (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_data_i  (out_if.data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .err_count_o (err_count),
    .pending_o   (pending),
    .results_o   (results),
    .frames_o    (frames)
  );

  always #1 clk_i = ~clk_i;

  function automatic int clamp_dim(input int v, input int hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic send_beat(input logic cell_bit, input logic fl);
    if (src_gaps) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_if.valid <= 1'b1;
    in_if.data <= '{cell_req: cell_bit, flush: fl};
    do @(posedge clk_i); while (!in_if.ready);
    beats_sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
  endtask

  // Threshold writes carry random upper bits, which the register must drop.
  task automatic configure(input int w, input int h, input int b, input int s,
                           input bit thresholds);
    write_reg(CFG_MAP_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_MAP_HEIGHT, CFG_DATA_W'(h));
    if (thresholds) begin
      write_reg(CFG_BIRTH_THR, {5'($urandom_range(0, 31)), 4'(b)});
      write_reg(CFG_SURVIVE_THR, {5'($urandom_range(0, 31)), 4'(s)});
    end
    cfg_we <= 1'b0;
    @(posedge clk_i);
    map_w = clamp_dim(w, DEF_MAX_WIDTH);
    map_h = clamp_dim(h, DEF_MAX_HEIGHT);
    settings++;
  endtask

  // The map cells are followed by one row plus one beat of mostly flushes to push out the
  // final cells.
  task automatic send_frame(input int dens, input int flush_pct, input bit hold_mid,
                            input bit pause_mid);
    for (int i = 0; i < map_w * map_h; i++) begin
      if (hold_mid && i == map_w * map_h / 2) hold_seq <= hold_seq + 1;
      if (pause_mid && i == map_w * map_h / 2) drain();
      send_beat($urandom_range(0, 99) < dens, $urandom_range(0, 99) < flush_pct);
    end
    for (int i = 0; i <= map_w; i++) send_beat($urandom_range(0, 1), $urandom_range(0, 99) < 70);
  endtask

  initial begin : receiver
    int seen_holds;
    seen_holds = 0;
    out_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_seq != seen_holds) begin
        seen_holds = hold_seq;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        out_if.ready <= !(sink_gaps && $urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Timeout after %0d cycles without a beat", quiet);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int w;
    int h;
    int b;
    int s;
    int dens;
    int small_items;
    int frame_no;
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Undersized geometry saturates to 3x3; the thresholds keep their reset values. A flush
    // inside the frame acts as an empty cell and cells after the frame are ignored.
    configure(0, 2, 0, 0, 1'b0);
    for (int i = 0; i < 9; i++) send_beat(CHEQUER[i], i == 4);
    send_beat(1'b1, 1'b0);
    send_beat(1'b1, 1'b1);
    send_beat(1'b0, 1'b0);
    send_beat(1'b1, 1'b0);
    drain();
    configure(MIN_SIZE, MIN_SIZE, 9, 8, 1'b1);
    send_frame(100, 0, 1'b0, 1'b0);

    small_items = 0;
    frame_no = 0;
    while (small_items < SMALL_ITEMS || frame_no <= 8) begin
      if (frame_no == 3) begin
        drain();
        src_gaps = 1'b0;
        sink_gaps <= 1'b0;
        configure(60, 0, 5, 4, 1'b1);
        send_frame(45, 5, 1'b0, 1'b1);
        drain();
        src_gaps = 1'b1;
        sink_gaps <= 1'b1;
      end else if (frame_no == 8) begin
        drain();
        configure(2, 60, 3, 5, 1'b1);
        send_frame(50, 5, 1'b1, 1'b0);
      end else begin
        if (map_w * map_h > 100 || $urandom_range(0, 2) == 0) begin
          w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
          h = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
          b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(2, 7);
          s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(2, 7);
          drain();
          configure(w, h, b, s, 1'b1);
        end
        case ($urandom_range(0, 5))
          0: dens = 0;
          1: dens = 100;
          default: dens = $urandom_range(25, 75);
        endcase
        send_frame(dens, ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 15), 1'b0, 1'b0);
        small_items += map_w * map_h + map_w + 1;
      end
      frame_no++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Summary: %0d input beats sent, %0d smoothed cells checked in %0d frames.",
             beats_sent, results, frames);
    $display("Summary: %0d register settings, maps from 3x3 up to 60 wide or 60 high.",
             settings);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (pending != 0) $display("%0d predicted cells never arrived", pending);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
